FILE: design/lpce_pkg.sv
// ----------------------------------------------------------------------------
// lpce_pkg
// Shared types, codes and helpers for the pixel chain nibble encoder.
// ----------------------------------------------------------------------------
package lpce_pkg;

   localparam int PIN_COUNT_DEF = 8;

   // Nibble patterns for one data bit
   localparam logic [3:0] NIBBLE_ZERO = 4'b1000;
   localparam logic [3:0] NIBBLE_ONE  = 4'b1110;

   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_REFRESH = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   localparam logic [1:0] CSR_ENABLED  = 2'd0;
   localparam logic [1:0] CSR_EXTENDED = 2'd1;
   localparam logic [1:0] CSR_GRB      = 2'd2;
   localparam logic [1:0] CSR_FILL8    = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  pin_index;
      logic [31:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [31:0] encoded_word;
      logic        gap_word;
      logic        last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [7:0] enabled_mask;
      logic [7:0] extended_mask;
      logic [7:0] grb_mask;
      logic [7:0] fill8_mask;
   } cfg_type;

   // Sequencer to output stage
   typedef struct packed {
      logic       valid;
      logic       gap;
      logic       last;
      logic [7:0] data;
   } seq_res_type;

   // Pins 8 and up have no mask bit
   function automatic logic mask_bit(input logic [7:0] mask, input logic [5:0] pin);
      return (pin < 6'd8) ? mask[pin[2:0]] : 1'b0;
   endfunction

   function automatic logic [31:0] encode_byte(input logic [7:0] b);
      logic [31:0] w;
      w = '0;
      for (int i = 0; i < 8; i++) begin
         w[4*i +: 4] = b[i] ? NIBBLE_ONE : NIBBLE_ZERO;
      end
      return w;
   endfunction

endpackage

FILE: design/lpce_seq.sv
// ----------------------------------------------------------------------------
// lpce_seq
// Frame sequencer: pixel store, pin/repeat/byte walk, gap words.
// ----------------------------------------------------------------------------
module lpce_seq #(
   parameter int PIN_COUNT = lpce_pkg::PIN_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  lpce_pkg::req_type     item,
   input  lpce_pkg::cfg_type     cfg,
   output lpce_pkg::seq_res_type res
);
   import lpce_pkg::*;

   localparam int CP_W   = $clog2(PIN_COUNT + 1);
   localparam int PIDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
   localparam int WIDX_W = (PIDX_W > 3) ? PIDX_W : 3;
   localparam logic [CP_W-1:0] PIN_END = CP_W'(PIN_COUNT);

   logic [31:0]     store_ff [PIN_COUNT];
   logic            running_ff, running_in;
   logic            forced_ff, forced_in;
   logic [CP_W-1:0] cur_pin_ff, cur_pin_in;
   logic [2:0]      repeat_ff, repeat_in;
   logic [1:0]      slot_ff, slot_in;
   logic            gap_sent_ff, gap_sent_in;

   logic [WIDX_W-1:0] wr_idx;
   logic              wr_en;
   logic [31:0]       px;
   logic              grb, ext;
   logic [CP_W-1:0]   ent_pin, ent_cur;
   logic              ent_forced, ent_ok;
   logic [2:0]        ent_rep;

   assign wr_idx = WIDX_W'(item.pin_index);
   assign wr_en  = adv && (item.op == OP_WRITE) && (32'(item.pin_index) < PIN_COUNT);
   assign px     = store_ff[cur_pin_ff[PIDX_W-1:0]];
   assign grb    = mask_bit(cfg.grb_mask, 6'(cur_pin_ff));
   assign ext    = mask_bit(cfg.extended_mask, 6'(cur_pin_ff));

   // Pin entry: pin 0 on a command, next pin after the last repeat on a tick
   always_comb begin
      ent_pin    = (item.op == OP_TICK) ? cur_pin_ff + CP_W'(1) : '0;
      ent_forced = (item.op == OP_REFRESH) ? 1'b1 :
                   (item.op == OP_WRITE) ? 1'b0 : forced_ff;
      ent_ok     = (ent_pin < PIN_END) &&
                   (ent_forced || mask_bit(cfg.enabled_mask, 6'(ent_pin)));
      ent_cur    = ent_ok ? ent_pin : PIN_END;
      ent_rep    = (ent_ok && mask_bit(cfg.fill8_mask, 6'(ent_pin))) ? 3'd7 : 3'd0;
   end

   always_comb begin
      running_in  = running_ff;
      forced_in   = forced_ff;
      cur_pin_in  = cur_pin_ff;
      repeat_in   = repeat_ff;
      slot_in     = slot_ff;
      gap_sent_in = gap_sent_ff;
      res         = '0;
      if (adv) begin
         unique case (item.op)
            OP_WRITE, OP_REFRESH: begin
               running_in  = 1'b1;
               forced_in   = ent_forced;
               gap_sent_in = 1'b0;
               cur_pin_in  = ent_cur;
               repeat_in   = ent_rep;
               slot_in     = '0;
            end
            OP_TICK: begin
               if (running_ff) begin
                  res.valid = 1'b1;
                  if (cur_pin_ff >= PIN_END) begin
                     res.gap = 1'b1;
                     if (!gap_sent_ff) begin
                        gap_sent_in = 1'b1;
                     end else begin
                        res.last   = 1'b1;
                        running_in = 1'b0;
                     end
                  end else begin
                     logic end_px;
                     end_px = 1'b0;
                     unique case (slot_ff)
                        2'd0: begin
                           res.data = grb ? px[15:8] : px[23:16];
                           slot_in  = 2'd1;
                        end
                        2'd1: begin
                           res.data = grb ? px[23:16] : px[15:8];
                           slot_in  = 2'd2;
                        end
                        2'd2: begin
                           res.data = px[7:0];
                           if (ext) slot_in = 2'd3;
                           else end_px = 1'b1;
                        end
                        default: begin
                           res.data = px[31:24];
                           end_px   = 1'b1;
                        end
                     endcase
                     if (end_px) begin
                        slot_in = '0;
                        if (repeat_ff != 3'd0) begin
                           repeat_in = repeat_ff - 3'd1;
                        end else begin
                           cur_pin_in = ent_cur;
                           repeat_in  = ent_rep;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         forced_ff   <= 1'b0;
         cur_pin_ff  <= '0;
         repeat_ff   <= '0;
         slot_ff     <= '0;
         gap_sent_ff <= 1'b0;
         for (int i = 0; i < PIN_COUNT; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         running_ff  <= running_in;
         forced_ff   <= forced_in;
         cur_pin_ff  <= cur_pin_in;
         repeat_ff   <= repeat_in;
         slot_ff     <= slot_in;
         gap_sent_ff <= gap_sent_in;
         if (wr_en) begin
            store_ff[wr_idx[PIDX_W-1:0]] <= item.pixel_value;
         end
      end
   end

endmodule

FILE: design/lpce_out.sv
// ----------------------------------------------------------------------------
// lpce_out
// Nibble encoding and result register.
// ----------------------------------------------------------------------------
module lpce_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  lpce_pkg::seq_res_type res,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output lpce_pkg::rsp_type     rsp_data
);
   import lpce_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;
   logic    load;

   assign load = adv && res.valid;

   always_comb begin
      valid_in = valid_ff;
      if (load) valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
      data_in.encoded_word  = res.gap ? '0 : encode_byte(res.data);
      data_in.gap_word      = res.gap;
      data_in.last_of_frame = res.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: design/led_pixel_chain_nibble_encoder_top.sv
// ----------------------------------------------------------------------------
// led_pixel_chain_nibble_encoder_top
// Pixel chain nibble encoder: a colour byte or gap word per frame tick.
// ----------------------------------------------------------------------------
// Path: a tick's item is held in the input register, then its word goes
// into the result register, which drives rsp; a busy rsp stalls both.
// Throughput: one item per cycle unless rsp stalls; single-pass sequencer.
// Reset clears the masks, the pixel store and the sequencer; no frame runs.
module led_pixel_chain_nibble_encoder_top #(
   parameter int PIN_COUNT = lpce_pkg::PIN_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lpce_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lpce_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);
   import lpce_pkg::*;

   cfg_type     cfg_ff;
   req_type     item_ff;
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_adv;
   seq_res_type res;

   assign s1_adv    = s1_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) s1_valid_in = 1'b1;
      else if (s1_adv) s1_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         cfg_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_ENABLED:  cfg_ff.enabled_mask  <= csr_wdata;
               CSR_EXTENDED: cfg_ff.extended_mask <= csr_wdata;
               CSR_GRB:      cfg_ff.grb_mask      <= csr_wdata;
               CSR_FILL8:    cfg_ff.fill8_mask    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   lpce_seq #(
      .PIN_COUNT(PIN_COUNT)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .adv  (s1_adv),
      .item (item_ff),
      .cfg  (cfg_ff),
      .res  (res)
   );

   lpce_out u_out (
      .clock    (clock),
      .reset    (reset),
      .adv      (s1_adv),
      .res      (res),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   // A held item must not be overwritten by a new one
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> !req_ready)
      else $error("input register overrun");

   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(item_ff)))
      else $error("held item lost or changed");

   a_last_is_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_of_frame) |-> rsp_data.gap_word)
      else $error("last word is not a gap word");

   a_gap_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.gap_word) |-> (rsp_data.encoded_word == '0))
      else $error("gap word not zero");

   a_result_from_tick: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (s1_adv && item_ff.op == OP_TICK))
      else $error("result from a non-tick item");
`endif

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pixel chain nibble encoder.
// Writes, refreshes and ticks are driven on the req channel under several
// mask settings. Every accepted item is run through a local model of the frame
// sequencer, and each word taken from rsp is compared against it in order.
// ----------------------------------------------------------------------------
module tb;
   import lpce_pkg::*;

   localparam int PINS        = PIN_COUNT_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int ROUND_ITEMS = 145;
   localparam int MAX_TICKS   = 80;
   localparam int HOLD_CYCLES = 200;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic     clock;
   logic     reset     = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   req_type  req_data  = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   rsp_type  rsp_data;
   logic       csr_we    = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   // model of the frame sequencer
   logic [7:0]  en_mask, ext_mask, grb_sel_mask, fill_mask;
   logic [31:0] pix_mem [PINS];
   logic        frame_on, frame_force, gap_sent;
   int          seq_pin, seq_repeat, seq_slot;

   req_type pending_q [$];
   rsp_type word_q [$];

   int  send_idle_pct = 18;
   int  recv_idle_pct = 67;
   logic req_taken = 1'b0;
   int  hold_left = 0;
   logic hold_done = 1'b0;
   int  cycle_count = 0;
   int  err_count = 0;
   int  round_items;
   int  n_items = 0, n_writes = 0, n_refresh = 0, n_ticks = 0;
   int  n_data_words = 0, n_gap_words = 0, n_settings = 0;

   led_pixel_chain_nibble_encoder_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [31:0] nibble_word(input logic [7:0] b);
      logic [31:0] w;
      w = '0;
      for (int i = 7; i >= 0; i--) begin
         w = {w[27:0], b[i] ? NIBBLE_ONE : NIBBLE_ZERO};
      end
      return w;
   endfunction

   // Enable and fill8 are sampled only when the sequencer lands on a pin
   task automatic enter_pin(input int p);
      seq_slot = 0;
      if (p >= PINS) begin
         seq_pin    = PINS;
         seq_repeat = 0;
      end else if (!frame_force && !en_mask[p]) begin
         seq_pin    = PINS;
         seq_repeat = 0;
      end else begin
         seq_pin    = p;
         seq_repeat = fill_mask[p] ? 7 : 0;
      end
   endtask

   task automatic start_frame(input logic forced);
      frame_on    = 1'b1;
      frame_force = forced;
      gap_sent    = 1'b0;
      enter_pin(0);
   endtask

   task automatic finish_pixel();
      if (seq_repeat > 0) begin
         seq_repeat--;
         seq_slot = 0;
      end else begin
         enter_pin(seq_pin + 1);
      end
   endtask

   task automatic encode_step(input req_type it);
      rsp_type     w;
      logic [31:0] px;
      logic [7:0]  sel;
      logic        grb, ext;
      case (it.op)
         OP_WRITE: begin
            pix_mem[it.pin_index] = it.pixel_value;
            start_frame(1'b0);
         end
         OP_REFRESH: start_frame(1'b1);
         OP_TICK: begin
            if (frame_on) begin
               if (seq_pin >= PINS) begin
                  w.encoded_word  = '0;
                  w.gap_word      = 1'b1;
                  w.last_of_frame = gap_sent;
                  if (gap_sent) frame_on = 1'b0;
                  gap_sent = 1'b1;
               end else begin
                  px  = pix_mem[seq_pin];
                  grb = grb_sel_mask[seq_pin];
                  ext = ext_mask[seq_pin];
                  case (seq_slot)
                     0: begin
                        sel = grb ? px[15:8] : px[23:16];
                        seq_slot = 1;
                     end
                     1: begin
                        sel = grb ? px[23:16] : px[15:8];
                        seq_slot = 2;
                     end
                     2: begin
                        sel = px[7:0];
                        if (ext) seq_slot = 3;
                        else finish_pixel();
                     end
                     default: begin
                        sel = px[31:24];
                        finish_pixel();
                     end
                  endcase
                  w.encoded_word  = nibble_word(sel);
                  w.gap_word      = 1'b0;
                  w.last_of_frame = 1'b0;
               end
               word_q.push_back(w);
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      err_count++;
      $display("ERROR cycle %0d: %s got %h want %h", cycle_count, field, got, want);
   endtask

   // input side prediction and result checking, both at the rising edge
   always @(posedge clock) begin : chk
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            n_items++;
            if (req_data.op == OP_WRITE) n_writes++;
            else if (req_data.op == OP_REFRESH) n_refresh++;
            else if (req_data.op == OP_TICK) n_ticks++;
            encode_step(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (word_q.size() == 0) begin
               report_mismatch("word with none pending", rsp_data.encoded_word, '0);
            end else begin
               want = word_q.pop_front();
               if (rsp_data.encoded_word !== want.encoded_word)
                  report_mismatch("encoded_word", rsp_data.encoded_word, want.encoded_word);
               if (rsp_data.gap_word !== want.gap_word)
                  report_mismatch("gap_word", 32'(rsp_data.gap_word), 32'(want.gap_word));
               if (rsp_data.last_of_frame !== want.last_of_frame)
                  report_mismatch("last_of_frame", 32'(rsp_data.last_of_frame),
                                  32'(want.last_of_frame));
               if (want.gap_word) n_gap_words++;
               else n_data_words++;
            end
         end
      end
      req_taken <= req_valid && req_ready;
   end

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= pending_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver; one long hold-off once the sender runs without gaps
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && !reset && send_idle_pct == 0 && req_valid &&
                   word_q.size() != 0) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, word_q.size());
         $display("simulation failed");
         $finish;
      end
   end

   task automatic push_item(input logic [1:0] op, input logic [2:0] pin,
                            input logic [31:0] val);
      req_type it;
      it.op          = op;
      it.pin_index   = pin;
      it.pixel_value = val;
      pending_q.push_back(it);
      if (op != OP_UNUSED) round_items++;
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || req_valid) @(posedge clock);
      while (word_q.size() != 0) @(posedge clock);
      // commands leave no word behind; let the pipeline settle
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ENABLED:  en_mask      = val;
         CSR_EXTENDED: ext_mask     = val;
         CSR_GRB:      grb_sel_mask = val;
         CSR_FILL8:    fill_mask    = val;
         default: ;
      endcase
   endtask

   task automatic apply_masks(input cfg_type cfg);
      write_reg(CSR_ENABLED,  cfg.enabled_mask);
      write_reg(CSR_EXTENDED, cfg.extended_mask);
      write_reg(CSR_GRB,      cfg.grb_mask);
      write_reg(CSR_FILL8,    cfg.fill8_mask);
      @(negedge clock);
      csr_we <= 1'b0;
      n_settings++;
   endtask

   // a command and, mostly, the ticks that carry its frame through the last gap word
   task automatic queue_burst();
      int          kind, flen, nt, p, r;
      logic        forced;
      logic [31:0] pv;
      kind = $urandom_range(99);
      r    = $urandom_range(9);
      pv   = (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff : $urandom;
      if (kind < 70) begin
         forced = ($urandom_range(4) == 0);
         if (forced) push_item(OP_REFRESH, 3'($urandom), $urandom);
         else push_item(OP_WRITE, 3'($urandom), pv);
         flen = 2;
         p    = 0;
         while (p < PINS && (forced || en_mask[p])) begin
            flen += (fill_mask[p] ? 8 : 1) * (ext_mask[p] ? 4 : 3);
            p++;
         end
         if (flen <= MAX_TICKS && $urandom_range(3) != 0)
            nt = flen + (($urandom_range(9) == 0) ? 1 : 0);
         else
            nt = $urandom_range(1, (flen < MAX_TICKS) ? flen : MAX_TICKS);
         repeat (nt) push_item(OP_TICK, 3'($urandom), $urandom);
      end else if (kind < 85) begin
         repeat ($urandom_range(1, 4)) push_item(OP_TICK, 3'($urandom), $urandom);
      end else if (kind < 93) begin
         push_item(OP_UNUSED, 3'($urandom), $urandom);
      end else begin
         push_item($urandom_range(1) ? OP_WRITE : OP_REFRESH, 3'($urandom), pv);
      end
   endtask

   initial begin : stim
      cfg_type cfg;
      int      s;
      en_mask = '0;
      ext_mask = '0;
      grb_sel_mask = '0;
      fill_mask = '0;
      for (int i = 0; i < PINS; i++) pix_mem[i] = '0;
      frame_on = 1'b0;
      frame_force = 1'b0;
      gap_sent = 1'b0;
      seq_pin = 0;
      seq_repeat = 0;
      seq_slot = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: short normal frames, forced refresh, restarts
      cfg.enabled_mask  = 8'h03;
      cfg.extended_mask = 8'h01;
      cfg.grb_mask      = 8'h02;
      cfg.fill8_mask    = 8'h00;
      apply_masks(cfg);
      round_items = 0;
      push_item(OP_TICK, 3'd0, 32'h0);          // no frame yet
      push_item(OP_UNUSED, 3'd7, 32'hffff_ffff);
      push_item(OP_WRITE, 3'd1, 32'h0000_0000);
      push_item(OP_WRITE, 3'd0, 32'h81ff_00c3);
      repeat (9) push_item(OP_TICK, 3'd7, 32'hffff_ffff);
      push_item(OP_TICK, 3'd0, 32'h0);          // frame already done
      push_item(OP_REFRESH, 3'd5, 32'h1234_5678);
      repeat (3) push_item(OP_TICK, 3'd0, 32'h0);
      push_item(OP_WRITE, 3'd7, 32'hffff_ffff); // restart mid-frame
      repeat (3) push_item(OP_TICK, 3'd0, 32'h0);
      push_item(OP_WRITE, 3'd2, 32'h00a5_5a00);
      push_item(OP_TICK, 3'd0, 32'h0);

      for (int ph = 0; ph < 3; ph++) begin
         for (int r = 0; r < 4; r++) begin
            wait_drained();
            send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 67 : 0;
            recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 18 : 0;
            s = ph * 4 + r;
            case (s)
               0: cfg = '1;
               1: cfg = '0;
               2: cfg = {8'hff, 8'hff, 8'h00, 8'h00};
               default: begin
                  cfg.enabled_mask  = 8'($urandom);
                  cfg.extended_mask = 8'($urandom);
                  cfg.grb_mask      = 8'($urandom);
                  // sparse, so that most frames finish within a burst
                  cfg.fill8_mask    = 8'($urandom & $urandom & $urandom);
               end
            endcase
            apply_masks(cfg);
            round_items = 0;
            while (round_items < ROUND_ITEMS) queue_burst();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      $display("covered %0d items (%0d writes, %0d refreshes, %0d ticks), %0d mask settings",
               n_items, n_writes, n_refresh, n_ticks, n_settings);
      $display("checked %0d colour words and %0d gap words, %0d errors",
               n_data_words, n_gap_words, err_count);
      if (err_count == 0 && word_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: led_pixel_chain_nibble_encoder_top.f
design/lpce_pkg.sv
design/lpce_seq.sv
design/lpce_out.sv
design/led_pixel_chain_nibble_encoder_top.sv
verif/tb.sv
